>>> rtl/core/v2d_pkg.sv
package v2d_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_NEG  = 3'd0,
    OP_LEN  = 3'd1,
    OP_NORM = 3'd2,
    OP_DIST = 3'd3,
    OP_DIR  = 3'd4
  } op_t;

  localparam int COMP_W     = 32;  // input component width
  localparam int VEC_W      = 33;  // difference / operand width
  localparam int SUM_W      = 66;  // sum of squares
  localparam int ROOT_W     = 33;  // square root
  localparam int SREM_W     = 36;  // square root remainder
  localparam int SQRT_CELLS = 33;  // one root bit per cell
  localparam int LEN_W      = 33;
  localparam int DREM_W     = 34;  // division remainder
  localparam int OUT_W      = 34;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 104;

  // payload that rides along the whole pipeline
  typedef struct packed {
    logic [2:0]              op;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
  } side_t;

  function automatic logic [VEC_W-1:0] mag33(input logic signed [VEC_W-1:0] v);
    logic [VEC_W-1:0] r;
    r = v[VEC_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

>>> rtl/core/vector2d_length_and_direction_unit.sv
// Pipeline from input beat to result: input, square, sum, 33 square-root cells, rounding,
//   divide setup, FRAC_BITS+2 divide cells, output.
// Throughput: one beat per cycle while out_tready stays high; every cell stage holds one item and passes it on.
// Backpressure stalls only the stages that hold data; bubbles collapse.
// Reset: synchronous active-low rst_n clears all valid flags; payload is not reset.
module vector2d_length_and_direction_unit
  import v2d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] op, [34:3] ax, [66:35] ay, [98:67] bx, [130:99] by, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [33:0] out_x, [67:34] out_y, [100:68] length, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] zero_vector
  output logic                  out_tuser
);

  localparam int QW = FRAC_BITS + 2;      // quotient bits
  localparam int NW = LEN_W + FRAC_BITS;  // scaled numerator bits

  // ---------------- stage a: operand select ----------------
  logic  a_v_r, a_en;
  side_t a_side_r, a_side_nxt;
  logic [2:0] in_op;
  logic signed [COMP_W-1:0] in_ax, in_ay, in_bx, in_by;
  logic  b_en;

  assign in_op = in_tdata[2:0];
  assign in_ax = in_tdata[34:3];
  assign in_ay = in_tdata[66:35];
  assign in_bx = in_tdata[98:67];
  assign in_by = in_tdata[130:99];

  always_comb begin
    a_side_nxt.op = in_op;
    if (in_op == OP_DIST || in_op == OP_DIR) begin
      a_side_nxt.vx = {in_bx[COMP_W-1], in_bx} - {in_ax[COMP_W-1], in_ax};
      a_side_nxt.vy = {in_by[COMP_W-1], in_by} - {in_ay[COMP_W-1], in_ay};
    end else begin
      a_side_nxt.vx = {in_ax[COMP_W-1], in_ax};
      a_side_nxt.vy = {in_ay[COMP_W-1], in_ay};
    end
  end

  assign a_en      = !a_v_r || b_en;
  assign in_tready = a_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_side_r <= a_side_nxt;
    end
  end

  // ---------------- stage b: squares ----------------
  logic             b_v_r, c_en;
  side_t            b_side_r;
  logic [SUM_W-1:0] sqx_r, sqy_r;
  logic [VEC_W-1:0] a_mx, a_my;

  assign a_mx = mag33(a_side_r.vx);
  assign a_my = mag33(a_side_r.vy);
  assign b_en = !b_v_r || c_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_side_r <= a_side_r;
      sqx_r    <= a_mx * a_mx;
      sqy_r    <= a_my * a_my;
    end
  end

  // ---------------- stage c: sum of squares ----------------
  logic             c_v_r;
  side_t            c_side_r;
  logic [SUM_W-1:0] sum_r;

  logic              sv     [SQRT_CELLS+1];
  logic              srdy   [SQRT_CELLS+1];
  side_t             sside  [SQRT_CELLS+1];
  logic [SUM_W-1:0]  srad   [SQRT_CELLS+1];
  logic [ROOT_W-1:0] sroot  [SQRT_CELLS+1];
  logic [SREM_W-1:0] srem   [SQRT_CELLS+1];

  assign c_en = !c_v_r || srdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_side_r <= b_side_r;
      sum_r    <= sqx_r + sqy_r;
    end
  end

  // ---------------- square root cell row ----------------
  assign sv[0]    = c_v_r;
  assign sside[0] = c_side_r;
  assign srad[0]  = sum_r;
  assign sroot[0] = '0;
  assign srem[0]  = '0;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    v2d_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[k]),
      .in_ready  (srdy[k]),
      .in_side   (sside[k]),
      .in_rad    (srad[k]),
      .in_root   (sroot[k]),
      .in_rem    (srem[k]),
      .out_valid (sv[k+1]),
      .out_ready (srdy[k+1]),
      .out_side  (sside[k+1]),
      .out_rad   (srad[k+1]),
      .out_root  (sroot[k+1]),
      .out_rem   (srem[k+1])
    );
  end

  // ---------------- stage r: round to nearest ----------------
  logic             r_v_r, r_en, i_en;
  side_t            r_side_r;
  logic [LEN_W-1:0] len_r;
  logic             rnd_up;

  assign rnd_up       = srem[SQRT_CELLS] > {{(SREM_W-ROOT_W){1'b0}}, sroot[SQRT_CELLS]};
  assign r_en         = !r_v_r || i_en;
  assign srdy[SQRT_CELLS] = r_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_en) begin
      r_v_r <= sv[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (r_en) begin
      r_side_r <= sside[SQRT_CELLS];
      len_r    <= sroot[SQRT_CELLS] + {{(LEN_W-1){1'b0}}, rnd_up};
    end
  end

  // ---------------- stage i: divide setup ----------------
  logic                   i_v_r;
  side_t                  i_side_r;
  logic [LEN_W-1:0]       i_len_r;
  logic [1:0][QW-1:0]     i_num_r;
  logic [1:0][DREM_W-1:0] i_rem_r;
  logic [NW-1:0]          nx, ny;

  logic                   dv   [QW+1];
  logic                   drdy [QW+1];
  side_t                  dside[QW+1];
  logic [LEN_W-1:0]       dlen [QW+1];
  logic [1:0][QW-1:0]     dnum [QW+1];
  logic [1:0][DREM_W-1:0] drem [QW+1];
  logic [1:0][QW-1:0]     dq   [QW+1];

  // numerator = |v| * 2^F + len/2
  assign nx = {mag33(r_side_r.vx), {FRAC_BITS{1'b0}}} + {{(NW-LEN_W+1){1'b0}}, len_r[LEN_W-1:1]};
  assign ny = {mag33(r_side_r.vy), {FRAC_BITS{1'b0}}} + {{(NW-LEN_W+1){1'b0}}, len_r[LEN_W-1:1]};
  assign i_en = !i_v_r || drdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
    end else if (i_en) begin
      i_v_r <= r_v_r;
    end
  end

  // quotient fits in QW bits, so the top part already sits below the divisor
  always_ff @(posedge clk) begin
    if (i_en) begin
      i_side_r   <= r_side_r;
      i_len_r    <= len_r;
      i_num_r[0] <= nx[QW-1:0];
      i_num_r[1] <= ny[QW-1:0];
      i_rem_r[0] <= {{(DREM_W-(NW-QW)){1'b0}}, nx[NW-1:QW]};
      i_rem_r[1] <= {{(DREM_W-(NW-QW)){1'b0}}, ny[NW-1:QW]};
    end
  end

  // ---------------- divider cell row ----------------
  assign dv[0]    = i_v_r;
  assign dside[0] = i_side_r;
  assign dlen[0]  = i_len_r;
  assign dnum[0]  = i_num_r;
  assign drem[0]  = i_rem_r;
  assign dq[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    v2d_div_cell #(.QW(QW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[k]),
      .in_ready  (drdy[k]),
      .in_side   (dside[k]),
      .in_len    (dlen[k]),
      .in_num    (dnum[k]),
      .in_rem    (drem[k]),
      .in_q      (dq[k]),
      .out_valid (dv[k+1]),
      .out_ready (drdy[k+1]),
      .out_side  (dside[k+1]),
      .out_len   (dlen[k+1]),
      .out_num   (dnum[k+1]),
      .out_rem   (drem[k+1]),
      .out_q     (dq[k+1])
    );
  end

  // ---------------- output stage ----------------
  logic                    o_v_r, o_en;
  logic signed [OUT_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic [LEN_W-1:0]        olen_r, olen_nxt;
  logic                    oz_r, oz_nxt;
  side_t                   fs;
  logic [OUT_W-1:0]        qx, qy;

  assign fs   = dside[QW];
  assign qx   = {{(OUT_W-QW){1'b0}}, dq[QW][0]};
  assign qy   = {{(OUT_W-QW){1'b0}}, dq[QW][1]};
  assign o_en = !o_v_r || out_tready;
  assign drdy[QW] = o_en;

  always_comb begin
    ox_nxt   = '0;
    oy_nxt   = '0;
    olen_nxt = '0;
    oz_nxt   = 1'b0;
    unique case (fs.op) inside
      OP_NEG: begin
        ox_nxt = -{fs.vx[VEC_W-1], fs.vx};
        oy_nxt = -{fs.vy[VEC_W-1], fs.vy};
      end
      OP_LEN, OP_DIST: begin
        olen_nxt = dlen[QW];
      end
      OP_NORM, OP_DIR: begin
        olen_nxt = dlen[QW];
        if (dlen[QW] == '0) begin
          oz_nxt = 1'b1;
        end else begin
          ox_nxt = fs.vx[VEC_W-1] ? -qx : qx;
          oy_nxt = fs.vy[VEC_W-1] ? -qy : qy;
        end
      end
      default: begin
        oz_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_en) begin
      o_v_r <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      olen_r <= olen_nxt;
      oz_r   <= oz_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {{(OUT_DATA_W-2*OUT_W-LEN_W){1'b0}}, olen_r, oy_r, ox_r};
  assign out_tuser  = oz_r;

  // zero-vector beats carry an all-zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && oz_r) |-> (ox_r == '0 && oy_r == '0 && olen_r == '0))
    else $error("zero-vector beat with nonzero payload");

  // a nonzero length never carries the zero-vector flag
  a_len_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && olen_r != '0) |-> !oz_r)
    else $error("zero-vector flag with nonzero length");

endmodule

>>> rtl/core/v2d_sqrt_cell.sv
module v2d_sqrt_cell
  import v2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  side_t             in_side,
  input  logic [SUM_W-1:0]  in_rad,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [SREM_W-1:0] in_rem,
  output logic              out_valid,
  input  logic              out_ready,
  output side_t             out_side,
  output logic [SUM_W-1:0]  out_rad,
  output logic [ROOT_W-1:0] out_root,
  output logic [SREM_W-1:0] out_rem
);

  logic              v_r;
  side_t             side_r;
  logic [SUM_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SREM_W-1:0] rem_r, rem_nxt;
  logic [SREM_W-1:0] rem2, trial;
  logic              en, ge;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  // one root bit: bring down two radicand bits, try (4*root + 1)
  always_comb begin
    rem2     = {in_rem[SREM_W-3:0], in_rad[SUM_W-1 -: 2]};
    trial    = {1'b0, in_root, 2'b01};
    ge       = rem2 >= trial;
    rem_nxt  = ge ? rem2 - trial : rem2;
    root_nxt = {in_root[ROOT_W-2:0], ge};
    rad_nxt  = {in_rad[SUM_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_rad   = rad_r;
  assign out_root  = root_r;
  assign out_rem   = rem_r;

  // partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (rem_r <= {{(SREM_W-ROOT_W-1){1'b0}}, root_r, 1'b0}))
    else $error("sqrt remainder out of range");

endmodule

>>> rtl/core/v2d_div_cell.sv
module v2d_div_cell
  import v2d_pkg::*;
#(
  parameter int QW = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  side_t                       in_side,
  input  logic [LEN_W-1:0]            in_len,
  input  logic [1:0][QW-1:0]          in_num,
  input  logic [1:0][DREM_W-1:0]      in_rem,
  input  logic [1:0][QW-1:0]          in_q,
  output logic                        out_valid,
  input  logic                        out_ready,
  output side_t                       out_side,
  output logic [LEN_W-1:0]            out_len,
  output logic [1:0][QW-1:0]          out_num,
  output logic [1:0][DREM_W-1:0]      out_rem,
  output logic [1:0][QW-1:0]          out_q
);

  logic                   v_r;
  side_t                  side_r;
  logic [LEN_W-1:0]       len_r;
  logic [1:0][QW-1:0]     num_r, num_nxt, q_r, q_nxt;
  logic [1:0][DREM_W-1:0] rem_r, rem_nxt;
  logic [DREM_W-1:0]      rem2;
  logic                   en, ge;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  // one restoring step per lane (x and y)
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem2       = {in_rem[i][DREM_W-2:0], in_num[i][QW-1]};
      ge         = rem2 >= {1'b0, in_len};
      rem_nxt[i] = ge ? rem2 - {1'b0, in_len} : rem2;
      q_nxt[i]   = {in_q[i][QW-2:0], ge};
      num_nxt[i] = {in_num[i][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      len_r  <= in_len;
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_len   = len_r;
  assign out_num   = num_r;
  assign out_rem   = rem_r;
  assign out_q     = q_r;

  // remainders stay below the divisor
  a_rem_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && len_r != '0) |-> (rem_r[0] < {1'b0, len_r} && rem_r[1] < {1'b0, len_r}))
    else $error("division remainder not below divisor");

endmodule

>>> tb/vector2d_length_and_direction_unit_test.sv
`timescale 1ns / 100ps

module vector2d_length_and_direction_unit_test
  import v2d_pkg::*;
();

  localparam int FRAC = 16;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [2:0] op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } vec_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] rx;
    logic [OUT_W-1:0] ry;
    logic [LEN_W-1:0] len;
    logic             zero;
  } vec_res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic in_tready_seen;

  vector2d_length_and_direction_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  vec_req_t pending_q[$];
  vec_res_t expected_q[$];
  int  errors = 0;
  int  quiet = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  hold_src = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // exact rounded root of dx^2 + dy^2
  function automatic logic [LEN_W-1:0] rounded_root(input logic [32:0] dx,
                                                   input logic [32:0] dy);
    logic [67:0] s, t2;
    logic [33:0] r, t;
    s = {35'd0, dx} * {35'd0, dx} + {35'd0, dy} * {35'd0, dy};
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (34'd1 << b);
      t2 = {34'd0, t} * {34'd0, t};
      if (t2 <= s) r = t;
    end
    if (s > {34'd0, r} * {34'd0, r} + {34'd0, r}) r = r + 34'd1;
    return r[LEN_W-1:0];
  endfunction

  // rounded d * 2^FRAC / len, ties away from zero
  function automatic logic [OUT_W-1:0] unit_comp(input logic signed [33:0] d,
                                                input logic [LEN_W-1:0] len);
    logic [33:0] m;
    logic [63:0] q;
    logic signed [34:0] sq;
    m = d[33] ? -d : d;
    q = (({30'd0, m} << FRAC) + ({31'd0, len} >> 1)) / {31'd0, len};
    sq = d[33] ? -$signed({1'b0, q[33:0]}) : $signed({1'b0, q[33:0]});
    return sq[OUT_W-1:0];
  endfunction

  function automatic vec_res_t predict_vector(input vec_req_t q);
    vec_res_t r;
    logic signed [33:0] vx, vy;
    r = '0;
    vx = 34'(q.ax);
    vy = 34'(q.ay);
    if (q.op == OP_DIST || q.op == OP_DIR) begin
      vx = 34'(q.bx) - 34'(q.ax);
      vy = 34'(q.by) - 34'(q.ay);
    end
    if (q.op == OP_NEG) begin
      r.rx = -34'(q.ax);
      r.ry = -34'(q.ay);
    end else if (q.op <= OP_DIR) begin
      r.len = rounded_root(vx[33] ? 33'(-vx) : 33'(vx), vy[33] ? 33'(-vy) : 33'(vy));
      if (q.op == OP_NORM || q.op == OP_DIR) begin
        if (r.len == 0) r.zero = 1'b1;
        else begin
          r.rx = unit_comp(vx, r.len);
          r.ry = unit_comp(vy, r.len);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver: new beat at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (pending_q.size() != 0 && !hold_src &&
          $urandom_range(99) >= src_idle_pct) begin
        vec_req_t q;
        q = pending_q.pop_front();
        in_tdata  <= {5'd0, q.by, q.bx, q.ay, q.ax, q.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // accept flag captured at the rising edge for the driver
  always @(posedge clk) begin
    if (!rst_n) in_tready_seen <= 1'b0;
    else in_tready_seen <= in_tvalid && in_tready;
  end

  // monitor: input beats make expectations, output beats are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        vec_req_t q;
        q.op = in_tdata[2:0];
        q.ax = in_tdata[34:3];
        q.ay = in_tdata[66:35];
        q.bx = in_tdata[98:67];
        q.by = in_tdata[130:99];
        expected_q.push_back(predict_vector(q));
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0)
          report_mismatch("unexpected beat", out_tdata[63:0], 64'd0);
        else begin
          vec_res_t e;
          e = expected_q.pop_front();
          if (out_tdata[33:0] !== e.rx)
            report_mismatch("out_x", 64'(out_tdata[33:0]), 64'(e.rx));
          if (out_tdata[67:34] !== e.ry)
            report_mismatch("out_y", 64'(out_tdata[67:34]), 64'(e.ry));
          if (out_tdata[100:68] !== e.len)
            report_mismatch("length", 64'(out_tdata[100:68]), 64'(e.len));
          if (out_tuser !== e.zero)
            report_mismatch("zero_vector", 64'(out_tuser), 64'(e.zero));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("vector2d_length_and_direction_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) - 1;
      2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(1 << 18);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  task automatic add_item(input logic [2:0] op, input logic [31:0] ax, input logic [31:0] ay,
                          input logic [31:0] bx, input logic [31:0] by);
    vec_req_t q;
    q.op = op; q.ax = ax; q.ay = ay; q.bx = bx; q.by = by;
    pending_q.push_back(q);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int drain;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, each op, zero vectors, unknown ops
    add_item(OP_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    add_item(OP_NEG, 0, 32'hFFFF_FFFF, 0, 0);
    add_item(OP_LEN, 32'h8000_0000, 32'h8000_0000, 0, 0);
    add_item(OP_LEN, 32'h0003_0000, 32'h0004_0000, 0, 0);
    add_item(OP_LEN, 0, 0, 0, 0);
    add_item(OP_NORM, 0, 0, 5, 5);
    add_item(OP_NORM, 32'h0001_0000, 0, 0, 0);
    add_item(OP_NORM, 1, 1, 0, 0);
    add_item(OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    add_item(OP_DIST, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(OP_DIST, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
    add_item(OP_DIR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(OP_DIR, 32'h1234_5678, 7, 32'h1234_5678, 7);
    add_item(OP_DIR, 0, 0, 32'hFFFF_FFFF, 1);
    add_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(3'd6, 1, 2, 3, 4);
    add_item(3'd7, 32'h8000_0000, 0, 0, 32'h8000_0000);
    wait_idle();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 60) : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 60) : 0;
      for (int i = 0; i < 300; i++) begin
        logic [31:0] ax;
        logic [31:0] ay;
        ax = rand_comp();
        ay = rand_comp();
        if ($urandom_range(9) == 0)
          add_item(3'($urandom_range(4)), ax, ay, ax, ay);
        else
          add_item($urandom_range(12) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4)),
                   ax, ay, rand_comp(), rand_comp());
        if (i == 150 && ph == 0) begin
          // hold the sender until the pipe is empty
          wait_idle();
          hold_src = 1;
          while (expected_q.size() != 0) @(posedge clk);
          hold_src = 0;
        end
      end
      wait_idle();
    end
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("vector2d_length_and_direction_unit regression: pass");
    end else begin
      $display("vector2d_length_and_direction_unit regression: fail");
    end
    $finish;
  end

endmodule
